// ===== src/slt_pkg.sv =====
// Shared types and constants of the sequence loss tracker.
// Used by the top level, the ratio divider and the port checker.
package slt_pkg;

	localparam int CHANNELS    = 16;
	localparam int COUNT_WIDTH = 32;
	localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	// received + lost; clamps only when the counters are already 64 bits wide
	localparam int TOT_W       = (COUNT_WIDTH < 64) ? COUNT_WIDTH + 1 : 64;
	localparam int PAIR_W      = 16;
	localparam int SEQ_W       = 8;
	localparam int PCT_W       = 15;
	localparam int PCT_IDX_W   = $clog2(PCT_W);
	localparam int STATUS_BITS = 5;
	localparam int OUT_W       = 32;

	localparam logic [PCT_W-1:0] PCT_SCALE     = PCT_W'(25600);
	localparam logic [7:0]       EXEMPT_RESET  = 8'hFF;

	typedef enum logic {
		OP_MESSAGE = 1'b0,
		OP_CLEAR   = 1'b1
	} op_t;

	typedef struct packed {
		op_t              opcode;
		logic [3:0]       channel;
		logic [7:0]       sender_system;
		logic [7:0]       sender_component;
		logic [SEQ_W-1:0] sequence_number;
	} req_t;

	typedef struct packed {
		logic [OUT_W-1:0] received_total;
		logic [OUT_W-1:0] lost_total;
		logic [7:0]       lost_now;
		logic [PCT_W-1:0] loss_percent;
		logic             status_due;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_COUNT,
		ST_TOTAL,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                   start;
		logic [COUNT_WIDTH-1:0] lost;
		logic [TOT_W-1:0]       total;
	} div_cmd_t;

	typedef struct packed {
		logic             done;
		logic [PCT_W-1:0] ratio;
	} div_sts_t;

endpackage

// ===== src/sequence_loss_tracker_top.sv =====
// Top level of the sequence loss tracker: pair table, per-channel counters, sequencer.
// Depends on slt_pkg and slt_ratio_div.
//
// Usage:
//   req channel (req_valid/req_ready/req) takes one request at a time: a received
//   message or a clear of one channel's counters. rsp channel (rsp_valid/rsp_ready/rsp)
//   returns exactly one response per request. cfg channel (cfg_valid/cfg_ready/cfg_data)
//   writes the exempt sender system id; it is always ready.
//   Sequence: a message request passes through LOOKUP, COUNT, TOTAL, DIV and FINISH
//   before rsp_valid rises; a clear or out-of-range channel goes straight to FINISH.
//   req_ready rises together with rsp_valid, so a request is taken only once the
//   previous one has left FINISH. The divider is serial: one compare-subtract per cycle,
//   15 quotient bits plus one extra step per set bit of the percent scale, 18 steps in all.
//   Reset: counters and percentages go to zero and the exempt id to 255. After reset
//   a clearing pass walks the 65536-entry pair table, one entry a cycle, and req_ready
//   stays low until the pass ends; cfg writes are taken meanwhile.
//   Receiver stall: the response register holds while rsp_ready is low; the next
//   request is still accepted and processed, and waits at the end for the register.
module sequence_loss_tracker_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  slt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output slt_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [7:0]    cfg_data
);
	import slt_pkg::*;

	state_t state_q, state_d;

	// pair table entry: {seen, last sequence number}
	logic [SEQ_W:0]    pair_mem [2**PAIR_W];
	logic [SEQ_W:0]    rd_q;
	logic              mem_we;
	logic [PAIR_W-1:0] mem_waddr;
	logic [SEQ_W:0]    mem_wdata;
	logic [PAIR_W-1:0] clr_q;

	logic [COUNT_WIDTH-1:0] rx_cnt_q   [CHANNELS];
	logic [COUNT_WIDTH-1:0] lost_cnt_q [CHANNELS];
	logic [PCT_W-1:0]       pct_q      [CHANNELS];

	req_t                   req_q;
	logic [CH_W-1:0]        ch_q;
	logic                   zero_q;
	logic [7:0]             exempt_q;
	logic [COUNT_WIDTH-1:0] rx_q;
	logic [COUNT_WIDTH-1:0] lost_q;
	logic [7:0]             lost_now_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic                   accept;
	logic                   ch_ok;
	logic [CH_W-1:0]        ch_in;
	logic                   fin_go;
	logic [SEQ_W-1:0]       expected;
	logic [7:0]             lost_now_d;
	logic [COUNT_WIDTH-1:0] rx_inc;
	logic [COUNT_WIDTH:0]   lost_sum;
	logic [COUNT_WIDTH-1:0] lost_sat;
	logic [COUNT_WIDTH:0]   tot_sum;
	logic [PCT_W:0]         pct_sum;
	logic [PCT_W-1:0]       pct_new;
	rsp_t                   rsp_d;
	div_cmd_t               div_cmd;
	div_sts_t               div_sts;

	assign accept    = req_valid && req_ready;
	assign ch_ok     = (32'(req.channel) < 32'(CHANNELS));
	assign ch_in     = CH_W'(req.channel);
	assign cfg_ready = 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE: begin
				if (req_valid) begin
					state_d = (!ch_ok || req.opcode == OP_CLEAR) ? ST_FINISH : ST_LOOKUP;
				end
			end
			ST_LOOKUP: state_d = ST_COUNT;
			ST_COUNT:  state_d = ST_TOTAL;
			ST_TOTAL:  state_d = ST_DIV;
			ST_DIV:    if (div_sts.done) state_d = ST_FINISH;
			ST_FINISH: if (!rsp_valid_q || rsp_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		fin_go    = 1'b0;
		unique case (state_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_IDLE:  req_ready = 1'b1;
			ST_LOOKUP: begin
				mem_we    = 1'b1;
				mem_waddr = {req_q.sender_system, req_q.sender_component};
				mem_wdata = {1'b1, req_q.sequence_number};
			end
			ST_FINISH: fin_go = !rsp_valid_q || rsp_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) pair_mem[mem_waddr] <= mem_wdata;
		if (accept) rd_q <= pair_mem[{req.sender_system, req.sender_component}];
	end

	// gap check, saturating counter updates, total and averaged percentage
	always_comb begin
		expected   = rd_q[SEQ_W-1:0] + 1'b1;
		lost_now_d = '0;
		if (rd_q[SEQ_W] && req_q.sequence_number != expected &&
		    req_q.sender_system != exempt_q) begin
			lost_now_d = req_q.sequence_number - expected;
		end
		rx_inc   = (rx_cnt_q[ch_q] == '1) ? rx_cnt_q[ch_q] : rx_cnt_q[ch_q] + 1'b1;
		lost_sum = {1'b0, lost_cnt_q[ch_q]} + (COUNT_WIDTH + 1)'(lost_now_q);
		lost_sat = lost_sum[COUNT_WIDTH] ? '1 : lost_sum[COUNT_WIDTH-1:0];
		tot_sum  = {1'b0, rx_q} + {1'b0, lost_q};
		pct_sum  = {1'b0, div_sts.ratio} + {1'b0, pct_q[ch_q]};
		pct_new  = pct_sum[PCT_W:1];
	end

	always_comb begin
		div_cmd.start = (state_q == ST_TOTAL);
		div_cmd.lost  = lost_q;
		div_cmd.total = (TOT_W == COUNT_WIDTH && tot_sum[COUNT_WIDTH]) ? '1
		                                                                : tot_sum[TOT_W-1:0];
	end

	always_comb begin
		rsp_d = '0;
		if (!zero_q) begin
			rsp_d.received_total = OUT_W'(rx_q);
			rsp_d.lost_total     = OUT_W'(lost_q);
			rsp_d.lost_now       = lost_now_q;
			rsp_d.loss_percent   = pct_new;
			rsp_d.status_due     = (rx_q[STATUS_BITS-1:0] == '0);
		end
	end

	slt_ratio_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.sts    (div_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			exempt_q    <= EXEMPT_RESET;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				rx_cnt_q[i]   <= '0;
				lost_cnt_q[i] <= '0;
				pct_q[i]      <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg_valid) exempt_q <= cfg_data;
			// clear opcode on a valid channel drops its counters right away
			if (accept && ch_ok && req.opcode == OP_CLEAR) begin
				rx_cnt_q[ch_in]   <= '0;
				lost_cnt_q[ch_in] <= '0;
				pct_q[ch_in]      <= '0;
			end
			if (state_q == ST_TOTAL) begin
				rx_cnt_q[ch_q]   <= rx_q;
				lost_cnt_q[ch_q] <= lost_q;
			end
			if (fin_go) begin
				if (!zero_q) pct_q[ch_q] <= pct_new;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req;
			ch_q   <= ch_in;
			zero_q <= !ch_ok || req.opcode == OP_CLEAR;
		end
		if (state_q == ST_LOOKUP) begin
			lost_now_q <= lost_now_d;
			rx_q       <= rx_inc;
		end
		if (state_q == ST_COUNT) lost_q <= lost_sat;
		if (fin_go) rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== src/slt_ratio_div.sv =====
// Serial divider: floor(lost * PCT_SCALE / total) with one shared compare-subtract.
// Depends on slt_pkg for widths and the command/status structs.
module slt_ratio_div (
	input  logic              clk,
	input  logic              arst_n,
	input  slt_pkg::div_cmd_t cmd,
	output slt_pkg::div_sts_t sts
);
	import slt_pkg::*;

	logic [TOT_W-1:0]     a_q;
	logic [TOT_W-1:0]     b_q;
	logic [TOT_W-1:0]     r_q;
	logic [PCT_W-1:0]     q_q;
	logic [PCT_IDX_W-1:0] bit_q;
	logic                 ph_q;
	logic                 busy_q;
	logic                 done_q;

	logic [TOT_W:0]   opnd;
	logic [TOT_W:0]   diff;
	logic             ge;
	logic [TOT_W-1:0] r_next;
	logic             last_step;

	// phase 0 doubles the remainder, phase 1 adds the numerator for a set scale bit
	always_comb begin
		opnd      = ph_q ? ({1'b0, r_q} + {1'b0, a_q}) : {r_q, 1'b0};
		ge        = (opnd >= {1'b0, b_q});
		diff      = opnd - {1'b0, b_q};
		r_next    = ge ? diff[TOT_W-1:0] : opnd[TOT_W-1:0];
		last_step = (bit_q == '0) && (ph_q || !PCT_SCALE[bit_q]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				ph_q   <= 1'b0;
				bit_q  <= PCT_IDX_W'(PCT_W - 1);
			end else if (busy_q) begin
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					ph_q   <= 1'b0;
				end else if (!ph_q && PCT_SCALE[bit_q]) begin
					ph_q <= 1'b1;
				end else begin
					ph_q  <= 1'b0;
					bit_q <= bit_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q <= TOT_W'(cmd.lost);
			b_q <= cmd.total;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			r_q <= r_next;
			if (ph_q) begin
				q_q <= q_q + PCT_W'(ge);
			end else begin
				q_q <= {q_q[PCT_W-2:0], ge};
			end
		end
	end

	assign sts.done  = done_q;
	assign sts.ratio = q_q;

endmodule

// ===== src/slt_checker.sv =====
// Port-level checks of the sequence loss tracker, bound to the top level.
// Depends on slt_pkg for the response type and the percent scale.
module slt_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input slt_pkg::rsp_t rsp
);
	import slt_pkg::*;

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one request in flight: busy right after acceptance
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one in flight");

	// an all-zero response comes only from clear or out-of-range requests
	a_zero_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.received_total == '0 |->
		rsp.lost_total == '0 && rsp.lost_now == '0 && rsp.loss_percent == '0 &&
		!rsp.status_due)
		else $error("zero receive count with nonzero fields");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.loss_percent <= PCT_SCALE)
		else $error("loss percent above 100");

endmodule

bind sequence_loss_tracker_top slt_checker u_slt_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for sequence_loss_tracker_top: directed table, then random traffic.
// Predicts per-channel loss counters and the smoothed percentage in SV.
// Depends on slt_pkg and the tracker RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import slt_pkg::*;

	localparam int          POOL          = 10;
	localparam int          DIRECTED_ROWS = 24;
	localparam int          PHASES        = 6;
	localparam int          PHASE_ITEMS   = 135;
	localparam int unsigned LIMIT_CYCLES  = 600000;

	typedef struct {
		req_t        item;
		bit          typed;
		int unsigned typed_received;
	} dir_row_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	req_t       req       = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	rsp_t       rsp;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data  = 8'h00;

	// predictor state
	bit                     pair_seen     [0:65535];
	logic [7:0]             pair_last_seq [0:65535];
	logic [COUNT_WIDTH-1:0] rx_count      [0:CHANNELS-1];
	logic [COUNT_WIDTH-1:0] loss_count    [0:CHANNELS-1];
	logic [PCT_W-1:0]       loss_pct      [0:CHANNELS-1];
	logic [7:0]             exempt_id     = EXEMPT_RESET;

	rsp_t        expected_stats [$];
	dir_row_t    dir_rows [DIRECTED_ROWS];
	logic [7:0]  pool_sys  [POOL];
	logic [7:0]  pool_comp [POOL];
	int unsigned req_idle_pct  = 0;
	int unsigned rsp_stall_pct = 0;
	int unsigned cycle_count   = 0;
	int unsigned error_count   = 0;
	int unsigned req_count     = 0;
	int unsigned clear_count   = 0;
	int unsigned rsp_count     = 0;
	int unsigned loss_rsp_count   = 0;
	int unsigned status_rsp_count = 0;

	sequence_loss_tracker_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_stats.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic rsp_t track_request(input req_t r);
		rsp_t        o;
		logic [15:0] pair;
		logic [7:0]  next_seq;
		logic [7:0]  gap;
		logic [32:0] loss_sum;
		logic [63:0] total;
		logic [63:0] ratio;
		o = '0;
		if (r.opcode == OP_CLEAR) begin
			rx_count[r.channel]   = '0;
			loss_count[r.channel] = '0;
			loss_pct[r.channel]   = '0;
		end else begin
			pair = {r.sender_system, r.sender_component};
			gap  = 8'd0;
			if (rx_count[r.channel] != '1)
				rx_count[r.channel] = rx_count[r.channel] + 1'b1;
			if (pair_seen[pair]) begin
				next_seq = pair_last_seq[pair] + 8'd1;
				if (r.sequence_number != next_seq && r.sender_system != exempt_id) begin
					gap      = r.sequence_number - next_seq;
					loss_sum = {1'b0, loss_count[r.channel]} + {25'd0, gap};
					loss_count[r.channel] = loss_sum[32] ? '1 : loss_sum[31:0];
				end
			end else begin
				pair_seen[pair] = 1'b1;
			end
			pair_last_seq[pair] = r.sequence_number;
			total = {32'd0, rx_count[r.channel]} + {32'd0, loss_count[r.channel]};
			ratio = ({32'd0, loss_count[r.channel]} * 64'd25600) / total;
			loss_pct[r.channel] = PCT_W'((ratio + {49'd0, loss_pct[r.channel]}) >> 1);
			o.received_total = rx_count[r.channel];
			o.lost_total     = loss_count[r.channel];
			o.lost_now       = gap;
			o.loss_percent   = loss_pct[r.channel];
			o.status_due     = (rx_count[r.channel][4:0] == 5'd0);
		end
		return o;
	endfunction

	function automatic dir_row_t mk_row(input op_t op, input logic [3:0] ch,
			input logic [7:0] sys, input logic [7:0] comp, input logic [7:0] seq,
			input bit typed, input int unsigned rcv);
		dir_row_t d;
		d.item.opcode           = op;
		d.item.channel          = ch;
		d.item.sender_system    = sys;
		d.item.sender_component = comp;
		d.item.sequence_number  = seq;
		d.typed                 = typed;
		d.typed_received        = rcv;
		return d;
	endfunction

	// mostly in-order sequences from a small pool of senders, some gaps, noise and clears
	function automatic req_t next_random_request();
		req_t        r;
		int unsigned pick;
		int unsigned roll;
		int unsigned slot;
		logic [15:0] pair;
		pick = $urandom_range(99);
		r.opcode           = OP_MESSAGE;
		r.channel          = ($urandom_range(99) < 60) ? 4'($urandom_range(3))
			: 4'($urandom_range(15));
		r.sender_system    = 8'($urandom_range(255));
		r.sender_component = 8'($urandom_range(255));
		r.sequence_number  = 8'($urandom_range(255));
		if (pick < 4) begin
			r.opcode = OP_CLEAR;
		end else if (pick >= 14) begin
			slot = $urandom_range(POOL - 1);
			r.sender_system    = pool_sys[slot];
			r.sender_component = pool_comp[slot];
			pair = {r.sender_system, r.sender_component};
			roll = $urandom_range(99);
			if (pair_seen[pair] && roll < 70)
				r.sequence_number = pair_last_seq[pair] + 8'd1;
			else if (pair_seen[pair] && roll < 85)
				r.sequence_number = pair_last_seq[pair] + 8'(2 + $urandom_range(3));
		end
		return r;
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		error_count++;
		if (error_count <= 10)
			$display("mismatch on %0s at response %0d: expected %0d, got %0d",
				what, rsp_count, want, got);
	endtask

	task automatic check_response(input rsp_t got);
		rsp_t want;
		rsp_count++;
		if (got.lost_now != 8'd0)
			loss_rsp_count++;
		if (got.status_due)
			status_rsp_count++;
		if (expected_stats.size() == 0) begin
			note_mismatch("response with nothing pending", 0, got.received_total);
		end else begin
			want = expected_stats.pop_front();
			if (got.received_total !== want.received_total)
				note_mismatch("received_total", want.received_total, got.received_total);
			if (got.lost_total !== want.lost_total)
				note_mismatch("lost_total", want.lost_total, got.lost_total);
			if (got.lost_now !== want.lost_now)
				note_mismatch("lost_now", want.lost_now, got.lost_now);
			if (got.loss_percent !== want.loss_percent)
				note_mismatch("loss_percent", want.loss_percent, got.loss_percent);
			if (got.status_due !== want.status_due)
				note_mismatch("status_due", want.status_due, got.status_due);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			check_response(rsp);
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// valid stays high between back-to-back requests; drop it only to idle
	task automatic send_request(input req_t item, input bit typed, input rsp_t typed_rsp);
		rsp_t predicted;
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		predicted = track_request(item);
		expected_stats.push_back(typed ? typed_rsp : predicted);
		req_count++;
		if (item.opcode == OP_CLEAR)
			clear_count++;
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (expected_stats.size() != 0);
	endtask

	task automatic write_exempt(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		exempt_id = value;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		rsp_t        typed_rsp;
		int unsigned mode;
		logic [7:0]  exempt_value;
		foreach (rx_count[c]) begin
			rx_count[c]   = '0;
			loss_count[c] = '0;
			loss_pct[c]   = '0;
		end
		// typed rows: first sight, in-order, exempt sender, after a clear, clears
		dir_rows[0]  = mk_row(OP_MESSAGE, 4'd0,  8'h01, 8'h01, 8'h00, 1'b1, 1);
		dir_rows[1]  = mk_row(OP_MESSAGE, 4'd0,  8'h01, 8'h01, 8'h01, 1'b1, 2);
		dir_rows[2]  = mk_row(OP_MESSAGE, 4'd0,  8'h01, 8'h01, 8'h03, 1'b0, 0);
		dir_rows[3]  = mk_row(OP_MESSAGE, 4'd0,  8'h01, 8'h01, 8'h03, 1'b0, 0);
		dir_rows[4]  = mk_row(OP_MESSAGE, 4'd15, 8'h00, 8'h00, 8'hFF, 1'b1, 1);
		dir_rows[5]  = mk_row(OP_MESSAGE, 4'd15, 8'h00, 8'h00, 8'h00, 1'b1, 2);
		dir_rows[6]  = mk_row(OP_MESSAGE, 4'd15, 8'h00, 8'h00, 8'h80, 1'b0, 0);
		dir_rows[7]  = mk_row(OP_MESSAGE, 4'd7,  8'hFF, 8'hFF, 8'h10, 1'b1, 1);
		dir_rows[8]  = mk_row(OP_MESSAGE, 4'd7,  8'hFF, 8'hFF, 8'h90, 1'b1, 2);
		dir_rows[9]  = mk_row(OP_MESSAGE, 4'd7,  8'hFF, 8'h00, 8'h00, 1'b1, 3);
		dir_rows[10] = mk_row(OP_MESSAGE, 4'd7,  8'hFF, 8'h00, 8'h05, 1'b1, 4);
		dir_rows[11] = mk_row(OP_MESSAGE, 4'd8,  8'h00, 8'hFF, 8'hAA, 1'b1, 1);
		dir_rows[12] = mk_row(OP_MESSAGE, 4'd9,  8'h00, 8'hFF, 8'hAB, 1'b1, 1);
		dir_rows[13] = mk_row(OP_MESSAGE, 4'd9,  8'h00, 8'hFF, 8'hAA, 1'b0, 0);
		dir_rows[14] = mk_row(OP_CLEAR,   4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 0);
		dir_rows[15] = mk_row(OP_MESSAGE, 4'd0,  8'h01, 8'h01, 8'h04, 1'b1, 1);
		dir_rows[16] = mk_row(OP_MESSAGE, 4'd0,  8'h01, 8'h01, 8'h06, 1'b0, 0);
		dir_rows[17] = mk_row(OP_CLEAR,   4'd15, 8'hFF, 8'hFF, 8'hFF, 1'b1, 0);
		dir_rows[18] = mk_row(OP_MESSAGE, 4'd15, 8'h00, 8'h00, 8'h81, 1'b1, 1);
		dir_rows[19] = mk_row(OP_MESSAGE, 4'd3,  8'hFE, 8'hFE, 8'h7F, 1'b1, 1);
		dir_rows[20] = mk_row(OP_MESSAGE, 4'd3,  8'hFE, 8'hFE, 8'h7E, 1'b0, 0);
		dir_rows[21] = mk_row(OP_MESSAGE, 4'd0,  8'h01, 8'h01, 8'h05, 1'b0, 0);
		dir_rows[22] = mk_row(OP_CLEAR,   4'd9,  8'h00, 8'h00, 8'h00, 1'b1, 0);
		dir_rows[23] = mk_row(OP_MESSAGE, 4'd9,  8'h00, 8'hFF, 8'hAB, 1'b1, 1);

		req_idle_pct  = 24;
		rsp_stall_pct = 48;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// exempt id still at its reset value for the table
		foreach (dir_rows[i]) begin
			typed_rsp = '0;
			typed_rsp.received_total = dir_rows[i].typed_received;
			send_request(dir_rows[i].item, dir_rows[i].typed, typed_rsp);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_for_results();
			mode          = phase / 2;
			req_idle_pct  = (mode == 0) ? 24 : (mode == 1) ? 48 : 0;
			rsp_stall_pct = (mode == 0) ? 48 : (mode == 1) ? 24 : 0;
			for (int i = 0; i < POOL; i++) begin
				pool_sys[i]  = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(255));
				pool_comp[i] = 8'($urandom_range(255));
			end
			case (phase)
				0:       exempt_value = 8'h00;
				1:       exempt_value = pool_sys[3];
				2:       exempt_value = 8'hFF;
				3:       exempt_value = 8'($urandom_range(255));
				4:       exempt_value = pool_sys[6];
				default: exempt_value = pool_sys[0];
			endcase
			write_exempt(exempt_value);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(99) < 2)
					wait_for_results();
				send_request(next_random_request(), 1'b0, '0);
			end
		end

		wait_for_results();
		repeat (40) @(posedge clk);
		$display("Summary: %0d requests (%0d clears) across %0d exempt-id settings, %0d checked",
			req_count, clear_count, PHASES, rsp_count);
		$display("Summary: %0d responses reported a sequence gap, %0d raised the status flag",
			loss_rsp_count, status_rsp_count);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches in total", error_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
